// ===== src/aebd_pkg.sv =====
// ----------------------------------------------------------------------------
// aebd_pkg
// Shared types and constants for the ADC event buffer decoder.
// ----------------------------------------------------------------------------
package aebd_pkg;

  // Input item: one status poll or one output buffer word
  typedef struct packed {
    logic        operation;
    logic [15:0] status_word;
    logic        readout_enabled;
    logic [31:0] buffer_word;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] adc_value;
    logic [15:0] adc_index;
    logic        last;
  } out_item_t;

  // Input operation codes
  localparam logic OP_STATUS = 1'b0;
  localparam logic OP_BUFFER = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_DATUM = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_SKIP  = 2'd3;

  // Buffer word type field, bits 26..24
  localparam int unsigned TYPE_LSB = 24;
  localparam int unsigned TYPE_MSB = 26;
  localparam logic [2:0] TYPE_DATA    = 3'd0;
  localparam logic [2:0] TYPE_HEADER  = 3'd2;
  localparam logic [2:0] TYPE_TRAILER = 3'd4;

  // Status word bits
  localparam int unsigned STAT_BUSY_BIT  = 2;
  localparam int unsigned STAT_READY_BIT = 0;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHANNEL_OFFSET  = 2'd0;
  localparam logic [1:0] CFG_BASE_INDEX      = 2'd1;
  localparam logic [1:0] CFG_BUSY_POLL_LIMIT = 2'd2;

  // Configuration reset values
  localparam logic [5:0]  CHANNEL_OFFSET_RST  = 6'd8;
  localparam logic [15:0] BASE_INDEX_RST      = 16'd0;
  localparam logic [9:0]  BUSY_POLL_LIMIT_RST = 10'd100;

  // Result a decode step hands to the output stage
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } dec_result_t;

endpackage

// ===== src/aebd_in_stage.sv =====
// ----------------------------------------------------------------------------
// aebd_in_stage
// Input register: captures one item and holds it until the decoder takes it.
// ----------------------------------------------------------------------------
module aebd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  aebd_pkg::in_item_t in_item,
  input  logic              take,
  output logic              item_valid,
  output aebd_pkg::in_item_t item
);

  logic               valid_r;
  logic               valid_nxt;
  aebd_pkg::in_item_t item_r;
  logic               load;

  // Accept when empty or when the held item leaves this cycle
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== src/aebd_decode.sv =====
// ----------------------------------------------------------------------------
// aebd_decode
// Event sequencer: status polls, header, data words and trailer.
// ----------------------------------------------------------------------------
module aebd_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  aebd_pkg::in_item_t    item,
  input  logic [5:0]            channel_offset,
  input  logic [15:0]           base_index,
  input  logic [9:0]            busy_poll_limit,
  output aebd_pkg::dec_result_t result
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_DATA    = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [9:0]  busy_polls_r, busy_polls_nxt;
  logic [5:0]  words_left_r, words_left_nxt;

  logic [9:0]  busy_inc;
  logic [5:0]  words_dec;
  logic [2:0]  word_type;
  logic [5:0]  chan;
  logic [15:0] idx;

  assign busy_inc  = busy_polls_r + 10'd1;
  assign words_dec = words_left_r - 6'd1;
  assign word_type = item.buffer_word[aebd_pkg::TYPE_MSB:aebd_pkg::TYPE_LSB];
  assign chan      = item.buffer_word[21:16];
  assign idx       = {10'd0, chan} - {10'd0, channel_offset} + base_index;

  always_comb begin
    phase_nxt      = phase_r;
    busy_polls_nxt = busy_polls_r;
    words_left_nxt = words_left_r;
    result         = '0;
    result.item.kind = aebd_pkg::KIND_DATUM;

    if (item_valid) begin
      case (phase_r)
        PH_IDLE: begin
          if (item.operation == aebd_pkg::OP_STATUS) begin
            if (item.status_word[aebd_pkg::STAT_BUSY_BIT]) begin
              if (busy_inc >= busy_poll_limit) begin
                // timeout: report and drop the count
                busy_polls_nxt   = '0;
                result.valid     = 1'b1;
                result.item.kind = aebd_pkg::KIND_ERROR;
                result.item.last = 1'b1;
              end else begin
                busy_polls_nxt = busy_inc;
              end
            end else begin
              busy_polls_nxt = '0;
              if (!item.readout_enabled) begin
                result.valid     = 1'b1;
                result.item.kind = aebd_pkg::KIND_SKIP;
                result.item.last = 1'b1;
              end else if (!item.status_word[aebd_pkg::STAT_READY_BIT]) begin
                result.valid     = 1'b1;
                result.item.kind = aebd_pkg::KIND_ERROR;
                result.item.last = 1'b1;
              end else begin
                phase_nxt = PH_HEADER;
              end
            end
          end
        end
        PH_HEADER: begin
          if (item.operation == aebd_pkg::OP_BUFFER) begin
            if (word_type != aebd_pkg::TYPE_HEADER) begin
              phase_nxt        = PH_IDLE;
              words_left_nxt   = '0;
              busy_polls_nxt   = '0;
              result.valid     = 1'b1;
              result.item.kind = aebd_pkg::KIND_ERROR;
              result.item.last = 1'b1;
            end else begin
              words_left_nxt = item.buffer_word[13:8];
              phase_nxt = (item.buffer_word[13:8] == 6'd0) ? PH_TRAILER : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (item.operation == aebd_pkg::OP_BUFFER) begin
            if (word_type != aebd_pkg::TYPE_DATA) begin
              phase_nxt        = PH_IDLE;
              words_left_nxt   = '0;
              busy_polls_nxt   = '0;
              result.valid     = 1'b1;
              result.item.kind = aebd_pkg::KIND_ERROR;
              result.item.last = 1'b1;
            end else begin
              words_left_nxt        = words_dec;
              if (words_dec == 6'd0) begin
                phase_nxt = PH_TRAILER;
              end
              result.valid          = 1'b1;
              result.item.kind      = aebd_pkg::KIND_DATUM;
              result.item.adc_value = item.buffer_word[12:0];
              result.item.adc_index = idx;
              result.item.last      = 1'b0;
            end
          end
        end
        PH_TRAILER: begin
          if (item.operation == aebd_pkg::OP_BUFFER) begin
            phase_nxt        = PH_IDLE;
            words_left_nxt   = '0;
            busy_polls_nxt   = '0;
            result.valid     = 1'b1;
            result.item.last = 1'b1;
            result.item.kind = (word_type == aebd_pkg::TYPE_TRAILER) ?
                               aebd_pkg::KIND_DONE : aebd_pkg::KIND_ERROR;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      busy_polls_r <= '0;
      words_left_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      busy_polls_r <= busy_polls_nxt;
      words_left_r <= words_left_nxt;
    end
  end

endmodule

// ===== src/aebd_out_stage.sv =====
// ----------------------------------------------------------------------------
// aebd_out_stage
// Result register with a skid entry; the decoder waits only while the skid entry is full.
// ----------------------------------------------------------------------------
module aebd_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  aebd_pkg::dec_result_t result,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_stall,
  output aebd_pkg::out_item_t   out_item
);

  logic                main_valid_r, main_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  aebd_pkg::out_item_t main_r;
  aebd_pkg::out_item_t skid_r;
  logic                pop;
  logic                load_main_new;
  logic                load_main_skid;
  logic                load_skid;

  assign space = !skid_valid_r;
  assign pop   = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_main_new  = 1'b0;
    load_main_skid = 1'b0;
    load_skid      = 1'b0;
    if (skid_valid_r) begin
      // decoder is held off while the skid entry is full
      if (pop) begin
        load_main_skid = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (result.valid) begin
      if (!main_valid_r || pop) begin
        load_main_new  = 1'b1;
        main_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    if (load_main_new) begin
      main_r <= result.item;
    end else if (load_main_skid) begin
      main_r <= skid_r;
    end
    if (load_skid) begin
      skid_r <= result.item;
    end
  end

  assign out_valid = main_valid_r;
  assign out_item  = main_r;

endmodule

// ===== src/adc_event_buffer_decoder.sv =====
// Items are registered in the input stage, decoded, then registered in the result
// stage. One item per cycle while the skid entry is empty, set by the single
// decode step between the two registers; a stalled result parks in the skid entry.
// Reset (rst_n low, synchronous) empties both stages, returns the sequencer to
// idle with zero counts, and loads the register defaults (offset 8, base 0,
// busy poll limit 100).
// ----------------------------------------------------------------------------
// adc_event_buffer_decoder
// Decodes status polls and header/data/trailer buffer words of one ADC event
// into datum, error, event-complete and event-skipped results.
// ----------------------------------------------------------------------------
module adc_event_buffer_decoder (
  input  logic                clk,
  input  logic                rst_n,
  // input transaction channel
  input  logic                in_valid,
  output logic                in_stall,
  input  aebd_pkg::in_item_t  in_item,
  // result transaction channel
  output logic                out_valid,
  input  logic                out_stall,
  output aebd_pkg::out_item_t out_item,
  // configuration write port
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  // Configuration registers
  logic [5:0]  channel_offset_r;
  logic [15:0] base_index_r;
  logic [9:0]  busy_poll_limit_r;

  // Stage handshake
  logic                  item_valid;
  aebd_pkg::in_item_t    item;
  logic                  out_space;
  logic                  take;
  aebd_pkg::dec_result_t result;

  // Configuration writes: index beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_offset_r  <= aebd_pkg::CHANNEL_OFFSET_RST;
      base_index_r      <= aebd_pkg::BASE_INDEX_RST;
      busy_poll_limit_r <= aebd_pkg::BUSY_POLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        aebd_pkg::CFG_CHANNEL_OFFSET:  channel_offset_r  <= cfg_wdata[5:0];
        aebd_pkg::CFG_BASE_INDEX:      base_index_r      <= cfg_wdata;
        aebd_pkg::CFG_BUSY_POLL_LIMIT: busy_poll_limit_r <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  // Advance the held item whenever the output side has a free entry; items
  // that give no result advance just the same.
  assign take = item_valid && out_space;

  aebd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Sequencer state only moves on the cycle the item is taken
  aebd_decode u_decode (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (take),
    .item            (item),
    .channel_offset  (channel_offset_r),
    .base_index      (base_index_r),
    .busy_poll_limit (busy_poll_limit_r),
    .result          (result)
  );

  aebd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .space     (out_space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== src/aebd_checker.sv =====
// ----------------------------------------------------------------------------
// aebd_checker
// Port-level checks for the ADC event buffer decoder, bound to the top level.
// ----------------------------------------------------------------------------
module aebd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input aebd_pkg::out_item_t out_item
);

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // A datum never ends the event
  a_datum_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == aebd_pkg::KIND_DATUM |-> !out_item.last)
    else $error("datum marked last");

  // Non-datum results end the event and carry zero payload
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind != aebd_pkg::KIND_DATUM |->
      out_item.last && out_item.adc_value == 13'd0 && out_item.adc_index == 16'd0)
    else $error("event end result malformed");

endmodule

bind adc_event_buffer_decoder aebd_checker u_aebd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== sim/aebd_checker.sv =====
// ----------------------------------------------------------------------------
// aebd_tb_checker
// Watches the input, result and configuration ports of the ADC event buffer
// decoder, predicts each result from the accepted input transactions and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module aebd_tb_checker
  import aebd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          error_count,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_HEADER,
    SEQ_DATA,
    SEQ_TRAILER
  } seq_phase_t;

  // predictor state and register copies
  seq_phase_t  seq;
  logic [9:0]  busy_count;
  logic [5:0]  words_left;
  logic [5:0]  chan_offset;
  logic [15:0] index_base;
  logic [9:0]  poll_limit;

  out_item_t   expected_results[$];

  // abandon the current event and report a format error
  function automatic out_item_t drop_event();
    out_item_t res;
    seq        = SEQ_IDLE;
    words_left = '0;
    busy_count = '0;
    res        = '0;
    res.kind   = KIND_ERROR;
    res.last   = 1'b1;
    return res;
  endfunction

  // advance the event sequence by one transaction; returns 1 with a result
  function automatic bit decode_item(input in_item_t it, output out_item_t res);
    logic [2:0] wtype;
    logic [5:0] chan;
    wtype    = it.buffer_word[TYPE_MSB:TYPE_LSB];
    chan     = it.buffer_word[21:16];
    res      = '0;
    res.last = 1'b1;

    if (seq == SEQ_IDLE) begin
      if (it.operation != OP_STATUS) return 1'b0;
      if (it.status_word[STAT_BUSY_BIT]) begin
        busy_count = busy_count + 10'd1;
        if (busy_count < poll_limit) return 1'b0;
        res = drop_event();
        return 1'b1;
      end
      busy_count = '0;
      if (!it.readout_enabled) begin
        res.kind = KIND_SKIP;
        return 1'b1;
      end
      if (!it.status_word[STAT_READY_BIT]) begin
        res = drop_event();
        return 1'b1;
      end
      seq = SEQ_HEADER;
      return 1'b0;
    end

    // polls are ignored once an event is under way
    if (it.operation == OP_STATUS) return 1'b0;

    case (seq)
      SEQ_HEADER: begin
        if (wtype != TYPE_HEADER) begin
          res = drop_event();
          return 1'b1;
        end
        words_left = it.buffer_word[13:8];
        seq = (words_left == '0) ? SEQ_TRAILER : SEQ_DATA;
        return 1'b0;
      end
      SEQ_DATA: begin
        if (wtype != TYPE_DATA) begin
          res = drop_event();
          return 1'b1;
        end
        res.kind      = KIND_DATUM;
        res.adc_value = it.buffer_word[12:0];
        res.adc_index = {10'd0, chan} - {10'd0, chan_offset} + index_base;
        res.last      = 1'b0;
        words_left    = words_left - 6'd1;
        if (words_left == '0) seq = SEQ_TRAILER;
        return 1'b1;
      end
      default: begin
        if (wtype != TYPE_TRAILER) begin
          res = drop_event();
          return 1'b1;
        end
        seq        = SEQ_IDLE;
        words_left = '0;
        busy_count = '0;
        res.kind   = KIND_DONE;
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      seq             = SEQ_IDLE;
      busy_count      = '0;
      words_left      = '0;
      chan_offset     = CHANNEL_OFFSET_RST;
      index_base      = BASE_INDEX_RST;
      poll_limit      = BUSY_POLL_LIMIT_RST;
      expected_results.delete();
      error_count     = 0;
      results_pending = 0;
    end else begin
      // compare the delivered result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: expected no result, got k=%0d v=%h i=%h l=%0b",
                   $time, out_item.kind, out_item.adc_value, out_item.adc_index,
                   out_item.last);
        end else begin
          want = expected_results.pop_front();
          if (out_item.kind !== want.kind || out_item.adc_value !== want.adc_value ||
              out_item.adc_index !== want.adc_index || out_item.last !== want.last) begin
            error_count++;
            $display("%0t: expected k=%0d v=%h i=%h l=%0b, got k=%0d v=%h i=%h l=%0b",
                     $time, want.kind, want.adc_value, want.adc_index, want.last,
                     out_item.kind, out_item.adc_value, out_item.adc_index,
                     out_item.last);
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (decode_item(in_item, got)) expected_results.push_back(got);
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_CHANNEL_OFFSET:  chan_offset = cfg_wdata[5:0];
          CFG_BASE_INDEX:      index_base  = cfg_wdata;
          CFG_BUSY_POLL_LIMIT: poll_limit  = cfg_wdata[9:0];
          default: ;
        endcase
      end

      results_pending = expected_results.size();
    end
  end

endmodule

// ===== sim/adc_event_buffer_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// adc_event_buffer_decoder_tb
// Drives status polls and output buffer words into the decoder: a directed
// run over the corner cases, then random events under several register
// settings with random sender gaps and receiver stalls. A checker beside the
// block predicts and compares every result; the top gives the verdict.
// ----------------------------------------------------------------------------
module adc_event_buffer_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aebd_pkg::*;

  localparam int        ITEMS_PER_PHASE = 230;
  localparam int        DIRECTED_ITEMS  = 30;
  localparam int        HOLD_CYCLES     = 64;   // long receiver hold-off
  localparam int        SETTLE_CYCLES   = 4;    // latency plus skid entry
  localparam longint    RUN_LIMIT_NS    = 5_000_000;

  // defects a random event can carry
  typedef enum int {
    FLAW_NONE,
    FLAW_SKIP,
    FLAW_NOT_READY,
    FLAW_HEADER,
    FLAW_DATA,
    FLAW_TRAILER
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  int          error_count;
  int          results_pending;
  int          items_sent;
  int          limit_now;
  bit          gaps_on;
  bit          hold_off_req;
  bit          hold_off_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  adc_event_buffer_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  aebd_tb_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .error_count     (error_count),
    .results_pending (results_pending)
  );

  // random fill for every field; callers then force the ones that matter
  function automatic in_item_t random_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  // any type code other than the one wanted
  function automatic logic [2:0] wrong_type(input logic [2:0] want);
    return want ^ 3'($urandom_range(1, 7));
  endfunction

  // Offer one transaction from a falling edge and hold it until accepted.
  // Valid stays high on return so back-to-back transactions need no toggle.
  task automatic send(input in_item_t it);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_poll(input logic busy, input logic ready, input logic enabled);
    in_item_t it;
    it = random_item();
    it.operation                  = OP_STATUS;
    it.status_word[STAT_BUSY_BIT] = busy;
    it.status_word[STAT_READY_BIT] = ready;
    it.readout_enabled            = enabled;
    send(it);
  endtask

  task automatic send_word(input logic [2:0] wtype, input logic [31:0] bits);
    in_item_t it;
    it = random_item();
    it.operation   = OP_BUFFER;
    it.buffer_word = bits;
    it.buffer_word[TYPE_MSB:TYPE_LSB] = wtype;
    send(it);
  endtask

  // Single register write; drops the write enable again before returning so writes never overlap.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [5:0] offset, input logic [15:0] base,
                            input logic [9:0] limit);
    write_reg(CFG_CHANNEL_OFFSET, {10'd0, offset});
    write_reg(CFG_BASE_INDEX, base);
    write_reg(CFG_BUSY_POLL_LIMIT, {6'd0, limit});
    limit_now = limit;
  endtask

  // Drop valid and wait until every predicted result has been delivered,
  // then let anything still in flight without a result settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One event: busy polls, final poll, header, data words, trailer.
  // Mostly well formed; some carry a defect or stray ignored transactions.
  task automatic random_event();
    int          nbusy;
    int          nwords;
    int          bad_slot;
    int          r;
    flaw_t       flaw;
    logic [31:0] bits;

    // stray buffer word while idle: ignored
    if ($urandom_range(0, 7) == 0) send_word(3'($urandom), $urandom);

    // usually a few busy polls; now and then enough to hit the limit
    if (limit_now <= 200 && $urandom_range(0, 7) == 0)
      nbusy = limit_now + $urandom_range(0, 2);
    else
      nbusy = $urandom_range(0, 3);
    repeat (nbusy) send_poll(1'b1, 1'($urandom), 1'($urandom));

    r    = $urandom_range(0, 11);
    flaw = (r < 5) ? flaw_t'(r + 1) : FLAW_NONE;

    case (flaw)
      FLAW_SKIP: begin
        send_poll(1'b0, 1'($urandom), 1'b0);
        return;
      end
      FLAW_NOT_READY: begin
        send_poll(1'b0, 1'b0, 1'b1);
        return;
      end
      default: send_poll(1'b0, 1'b1, 1'b1);
    endcase

    r = $urandom_range(0, 19);
    nwords = (r == 0) ? 63 : (r == 1) ? 0 : $urandom_range(1, 8);
    if (flaw == FLAW_DATA && nwords == 0) nwords = 1;
    bad_slot = (nwords > 0) ? $urandom_range(0, nwords - 1) : 0;

    bits = $urandom;
    bits[13:8] = 6'(nwords);
    if (flaw == FLAW_HEADER) begin
      send_word(wrong_type(TYPE_HEADER), bits);
      return;
    end
    send_word(TYPE_HEADER, bits);

    for (int i = 0; i < nwords; i++) begin
      // status poll inside the event: ignored
      if ($urandom_range(0, 9) == 0) send_poll(1'($urandom), 1'($urandom), 1'($urandom));
      if (flaw == FLAW_DATA && i == bad_slot) begin
        send_word(wrong_type(TYPE_DATA), $urandom);
        return;
      end
      send_word(TYPE_DATA, $urandom);
    end

    send_word((flaw == FLAW_TRAILER) ? wrong_type(TYPE_TRAILER) : TYPE_TRAILER, $urandom);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block backs up and stalls the sender.
  initial begin : receiver
    out_stall     = 1'b0;
    hold_off_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_CHANNEL_OFFSET;
    cfg_wdata    = '0;
    items_sent   = 0;
    limit_now    = BUSY_POLL_LIMIT_RST;
    gaps_on      = 1'b1;
    hold_off_req = 1'b0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed, reset register values (offset 8, base 0, limit 100) ---
    send_poll(1'b0, 1'b1, 1'b0);                 // readout bit clear: skip
    send_poll(1'b0, 1'b0, 1'b1);                 // no data ready: error
    send_word(TYPE_HEADER, 32'hFFFF_FFFF);       // buffer word while idle: drop
    repeat (3) send_poll(1'b1, 1'b1, 1'b1);      // busy, below the limit
    send_poll(1'b0, 1'b1, 1'b1);                 // ready: clears busy count
    send_poll(1'b0, 1'b0, 1'b0);                 // poll inside event: drop
    send_word(TYPE_HEADER, 32'hFFFF_C3FF);       // three words, other bits set
    send_word(TYPE_DATA, 32'hFFC0_FFFF);         // channel 0, full value: index wraps
    send_word(TYPE_DATA, 32'h003F_0000);         // channel 63, value 0
    send_word(TYPE_DATA, 32'h0008_0A5A);         // channel equal to offset: index 0
    send_word(TYPE_TRAILER, 32'h0000_0000);

    send_poll(1'b0, 1'b1, 1'b1);                 // empty event
    send_word(TYPE_HEADER, 32'h0000_0000);
    send_word(TYPE_TRAILER, 32'hFFFF_FFFF);

    send_poll(1'b0, 1'b1, 1'b1);                 // header with trailer type
    send_word(TYPE_TRAILER, 32'h0000_0100);

    send_poll(1'b0, 1'b1, 1'b1);                 // data word with bad type
    send_word(TYPE_HEADER, 32'h0000_0200);
    send_word(wrong_type(TYPE_DATA), $urandom);

    send_poll(1'b0, 1'b1, 1'b1);                 // trailer with header type
    send_word(TYPE_HEADER, 32'h0000_0000);
    send_word(TYPE_HEADER, 32'h0000_0000);
    drain();

    // busy timeout with a small limit; a ready poll resets the count
    set_config(6'd0, 16'hFFFF, 10'd3);
    repeat (2) send_poll(1'b1, 1'b0, 1'b1);
    send_poll(1'b0, 1'b1, 1'b0);
    repeat (3) send_poll(1'b1, 1'b1, 1'b1);

    // --- random events under several register settings ---
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       ;  // keep the setting from the busy timeout check
        1:       set_config(6'd63, 16'd0, 10'd1);
        2:       set_config(6'd63, 16'hFFFF, 10'd1023);
        3:       set_config(6'($urandom), 16'($urandom), 10'($urandom_range(2, 40)));
        4:       set_config(6'($urandom), 16'($urandom), 10'($urandom_range(1, 1023)));
        default: set_config(CHANNEL_OFFSET_RST, BASE_INDEX_RST, BUSY_POLL_LIMIT_RST);
      endcase
      if (p == 1) hold_off_req = 1'b1;
      gaps_on = (p != 5);  // run the last phase at full rate
      while (items_sent < DIRECTED_ITEMS + (p + 1) * ITEMS_PER_PHASE) random_event();
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
